[hdl/ate_pkg.sv]
// ----------------------------------------------------------------------------
// ate_pkg: accelerometer tilt estimator shared definitions
// Word types, configuration struct, CORDIC request/response and the arctangent
// table used by the vectoring unit.
// ----------------------------------------------------------------------------
package ate_pkg;

	localparam int ATE_CORDIC_STEPS = 16;

	// APB register port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// CORDIC datapath: coordinates scaled by 2^8, angle in 2^-16 degree
	localparam int CORDIC_W     = 27;
	localparam int ANG_W        = CORDIC_W - 9;
	localparam int CORDIC_SCALE = 8;
	localparam int ATAN_W       = 22;

	localparam logic signed [CORDIC_W-1:0] ACC_HALF_TURN = CORDIC_W'(11796480);
	localparam logic signed [CORDIC_W-1:0] ACC_ROUND     = CORDIC_W'(256);

	localparam logic signed [ANG_W-1:0] PITCH_LIM = ANG_W'(11520);
	localparam logic signed [ANG_W-1:0] ROLL_LIM  = ANG_W'(23040);

	localparam logic [8:0] SMOOTH_ONE = 9'd256;

	typedef enum logic [2:0] {
		REG_OFFSET_X  = 3'd0,
		REG_OFFSET_Y  = 3'd1,
		REG_OFFSET_Z  = 3'd2,
		REG_SMOOTHING = 3'd3,
		REG_FILTER_ON = 3'd4,
		REG_MIN_MAG   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_word_t;

	typedef struct packed {
		logic signed [14:0] pitch_deg;
		logic signed [15:0] roll_deg;
		logic               status;
	} out_word_t;

	typedef struct packed {
		logic signed [15:0] offset_x;
		logic signed [15:0] offset_y;
		logic signed [15:0] offset_z;
		logic [8:0]         smoothing;
		logic               filter_on;
		logic [14:0]        min_magnitude;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic signed [16:0] num;
		logic signed [16:0] den;
	} cordic_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [ANG_W-1:0] angle;
	} cordic_rsp_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [ATAN_W-1:0] atan_step(input logic [4:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740966;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117266;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[hdl/accel_tilt_estimator.sv]
// ----------------------------------------------------------------------------
// accel_tilt_estimator: pitch/roll from a 3-axis sample, optional EMA smoothing
// A new sample is accepted once the last result sits in the output register;
// the work runs through one shared 17x17 multiplier, a 16-step root and two
// passes through the single CORDIC unit. Async reset clears filter state.
// ----------------------------------------------------------------------------
module accel_tilt_estimator #(
	parameter int CORDIC_STEPS = ate_pkg::ATE_CORDIC_STEPS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ate_pkg::APB_AW-1:0]  paddr,
	input  logic [ate_pkg::APB_DW-1:0]  pwdata,
	output logic [ate_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        smp_valid,
	output logic                        smp_ready,
	input  ate_pkg::in_word_t           smp_data,
	output logic                        tilt_valid,
	input  logic                        tilt_ready,
	output ate_pkg::out_word_t          tilt_data
);
	import ate_pkg::*;

	localparam int EW = 25;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_MUL    = 10'b00_0000_0010,
		S_DRAIN  = 10'b00_0000_0100,
		S_CMP    = 10'b00_0000_1000,
		S_SQRT   = 10'b00_0001_0000,
		S_PSTART = 10'b00_0010_0000,
		S_PITCH  = 10'b00_0100_0000,
		S_RSTART = 10'b00_1000_0000,
		S_ROLL   = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	typedef enum logic [3:0] {
		OP_FX  = 4'd0,
		OP_CX  = 4'd1,
		OP_FY  = 4'd2,
		OP_CY  = 4'd3,
		OP_FZ  = 4'd4,
		OP_CZ  = 4'd5,
		OP_SX  = 4'd6,
		OP_SY  = 4'd7,
		OP_SZ  = 4'd8,
		OP_THR = 4'd9
	} op_t;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] d);
		if (d[16] != d[15])
			return d[16] ? 16'sh8000 : 16'sh7fff;
		return d[15:0];
	endfunction

	function automatic logic signed [ANG_W-1:0] clamp_ang(
		input logic signed [ANG_W-1:0] a,
		input logic signed [ANG_W-1:0] lim
	);
		if (a > lim)
			return lim;
		if (a < -lim)
			return -lim;
		return a;
	endfunction

	cfg_t        cfg;
	cordic_req_t cor_req;
	cordic_rsp_t cor_rsp;

	state_t state_q;
	op_t    op_q, mop_s1;
	logic   mv_s1;

	logic signed [15:0] vx_q, vy_q, vz_q;
	logic signed [15:0] filt_x_q, filt_y_q, filt_z_q;
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod_s1;
	logic signed [EW-1:0] ema_acc_q, ema_sum;
	logic signed [15:0] ema_new;
	logic [8:0]  smooth_c;
	logic [30:0] sx_q;
	logic [31:0] ryz_q;
	logic [29:0] thr_q;
	logic        low_mag;

	logic [31:0] sq_n_q, sq_root_q, sq_bit_q;
	logic [32:0] sq_try;
	logic        sq_take;

	logic signed [14:0] pitch_q;
	logic signed [15:0] roll_q;
	logic               status_q;
	logic signed [ANG_W-1:0] pitch_cl, roll_cl;

	logic      out_valid_q, out_free;
	out_word_t out_q;

	ate_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ate_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	assign smp_ready  = (state_q == S_IDLE);
	assign tilt_valid = out_valid_q;
	assign tilt_data  = out_q;
	assign out_free   = !out_valid_q || tilt_ready;

	// shared multiplier operands
	assign smooth_c = SMOOTH_ONE - cfg.smoothing;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (op_q)
			OP_FX: begin
				mul_a = {8'b0, cfg.smoothing};
				mul_b = {filt_x_q[15], filt_x_q};
			end
			OP_CX: begin
				mul_a = {8'b0, smooth_c};
				mul_b = {vx_q[15], vx_q};
			end
			OP_FY: begin
				mul_a = {8'b0, cfg.smoothing};
				mul_b = {filt_y_q[15], filt_y_q};
			end
			OP_CY: begin
				mul_a = {8'b0, smooth_c};
				mul_b = {vy_q[15], vy_q};
			end
			OP_FZ: begin
				mul_a = {8'b0, cfg.smoothing};
				mul_b = {filt_z_q[15], filt_z_q};
			end
			OP_CZ: begin
				mul_a = {8'b0, smooth_c};
				mul_b = {vz_q[15], vz_q};
			end
			OP_SX: begin
				mul_a = {vx_q[15], vx_q};
				mul_b = {vx_q[15], vx_q};
			end
			OP_SY: begin
				mul_a = {vy_q[15], vy_q};
				mul_b = {vy_q[15], vy_q};
			end
			OP_SZ: begin
				mul_a = {vz_q[15], vz_q};
				mul_b = {vz_q[15], vz_q};
			end
			OP_THR: begin
				mul_a = {2'b0, cfg.min_magnitude};
				mul_b = {2'b0, cfg.min_magnitude};
			end
			default: ;
		endcase
	end

	// EMA second half: old-weighted term already in ema_acc_q
	assign ema_sum = ema_acc_q + prod_s1[EW-1:0];
	assign ema_new = ema_sum[23:8];

	assign low_mag = ({2'b0, sx_q} + {1'b0, ryz_q}) < {3'b0, thr_q};

	assign sq_try  = {1'b0, sq_root_q} + {1'b0, sq_bit_q};
	assign sq_take = {1'b0, sq_n_q} >= sq_try;

	always_comb begin
		cor_req.start = (state_q == S_PSTART) || (state_q == S_RSTART);
		if (state_q == S_PSTART) begin
			cor_req.num = 17'sd0 - {vx_q[15], vx_q};
			cor_req.den = {1'b0, sq_root_q[15:0]};
		end else begin
			cor_req.num = {vy_q[15], vy_q};
			cor_req.den = {vz_q[15], vz_q};
		end
	end

	assign pitch_cl = clamp_ang(cor_rsp.angle, PITCH_LIM);
	assign roll_cl  = clamp_ang(cor_rsp.angle, ROLL_LIM);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_FX;
			mv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mv_s1 <= (state_q == S_MUL);
			if ((state_q == S_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (tilt_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (smp_valid) begin
						state_q <= S_MUL;
						op_q    <= cfg.filter_on ? OP_FX : OP_SX;
					end
				end
				S_MUL: begin
					if (op_q == OP_THR)
						state_q <= S_DRAIN;
					else
						op_q <= op_t'(op_q + 4'd1);
				end
				S_DRAIN:  state_q <= S_CMP;
				S_CMP:    state_q <= low_mag ? S_DONE : S_SQRT;
				S_SQRT: begin
					if (sq_bit_q[0])
						state_q <= S_PSTART;
				end
				S_PSTART: state_q <= S_PITCH;
				S_PITCH: begin
					if (cor_rsp.done)
						state_q <= S_RSTART;
				end
				S_RSTART: state_q <= S_ROLL;
				S_ROLL: begin
					if (cor_rsp.done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_x_q <= '0;
			filt_y_q <= '0;
			filt_z_q <= '0;
		end else if (mv_s1) begin
			if (mop_s1 == OP_CX)
				filt_x_q <= ema_new;
			if (mop_s1 == OP_CY)
				filt_y_q <= ema_new;
			if (mop_s1 == OP_CZ)
				filt_z_q <= ema_new;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		mop_s1  <= op_q;

		if ((state_q == S_IDLE) && smp_valid) begin
			vx_q <= sat16({smp_data.accel_x[15], smp_data.accel_x}
				- {cfg.offset_x[15], cfg.offset_x});
			vy_q <= sat16({smp_data.accel_y[15], smp_data.accel_y}
				- {cfg.offset_y[15], cfg.offset_y});
			vz_q <= sat16({smp_data.accel_z[15], smp_data.accel_z}
				- {cfg.offset_z[15], cfg.offset_z});
		end else if (mv_s1) begin
			unique case (mop_s1)
				OP_FX, OP_FY, OP_FZ: ema_acc_q <= prod_s1[EW-1:0];
				OP_CX:  vx_q  <= ema_new;
				OP_CY:  vy_q  <= ema_new;
				OP_CZ:  vz_q  <= ema_new;
				OP_SX:  sx_q  <= prod_s1[30:0];
				OP_SY:  ryz_q <= {1'b0, prod_s1[30:0]};
				OP_SZ:  ryz_q <= ryz_q + {1'b0, prod_s1[30:0]};
				OP_THR: thr_q <= prod_s1[29:0];
				default: ;
			endcase
		end

		// integer square root of y^2 + z^2, two radicand bits per step
		if (state_q == S_CMP) begin
			sq_n_q    <= ryz_q;
			sq_root_q <= '0;
			sq_bit_q  <= 32'h4000_0000;
		end else if (state_q == S_SQRT) begin
			if (sq_take) begin
				sq_n_q    <= sq_n_q - sq_try[31:0];
				sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
			end else begin
				sq_root_q <= sq_root_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end

		if (state_q == S_CMP) begin
			status_q <= low_mag;
			pitch_q  <= '0;
			roll_q   <= '0;
		end
		if ((state_q == S_PITCH) && cor_rsp.done)
			pitch_q <= pitch_cl[14:0];
		if ((state_q == S_ROLL) && cor_rsp.done)
			roll_q <= roll_cl[15:0];

		if ((state_q == S_DONE) && out_free) begin
			out_q.pitch_deg <= pitch_q;
			out_q.roll_deg  <= roll_q;
			out_q.status    <= status_q;
		end
	end

`ifndef SYNTHESIS
	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status |-> (out_q.pitch_deg == '0) && (out_q.roll_deg == '0))
		else $error("low-magnitude word carries angles");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.pitch_deg <= 15'sd11520) && (out_q.pitch_deg >= -15'sd11520))
		else $error("pitch out of range");

	a_cmp_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> $past(state_q == S_DRAIN))
		else $error("threshold compare before multiplier drained");

	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PSTART) |-> (sq_bit_q == '0) && (sq_root_q[31:16] == '0))
		else $error("square root not finished or out of range");
`endif

endmodule

[hdl/ate_cfg.sv]
// ----------------------------------------------------------------------------
// ate_cfg: configuration registers
// APB register file for offsets, smoothing weight, filter enable and the
// magnitude threshold. Smoothing writes above 1.0 are held at 1.0.
// ----------------------------------------------------------------------------
module ate_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ate_pkg::APB_AW-1:0]  paddr,
	input  logic [ate_pkg::APB_DW-1:0]  pwdata,
	output logic [ate_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output ate_pkg::cfg_t               cfg
);
	import ate_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;
	logic [8:0] smooth_wr;

	assign pready    = 1'b1;
	assign idx       = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en     = psel && penable && pwrite && pready;
	assign smooth_wr = (pwdata[8:0] > SMOOTH_ONE) ? SMOOTH_ONE : pwdata[8:0];
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x      <= '0;
			cfg_q.offset_y      <= '0;
			cfg_q.offset_z      <= '0;
			cfg_q.smoothing     <= 9'd51;
			cfg_q.filter_on     <= 1'b1;
			cfg_q.min_magnitude <= 15'd205;
		end else if (wr_en) begin
			unique case (idx)
				REG_OFFSET_X:  cfg_q.offset_x      <= pwdata[15:0];
				REG_OFFSET_Y:  cfg_q.offset_y      <= pwdata[15:0];
				REG_OFFSET_Z:  cfg_q.offset_z      <= pwdata[15:0];
				REG_SMOOTHING: cfg_q.smoothing     <= smooth_wr;
				REG_FILTER_ON: cfg_q.filter_on     <= pwdata[0];
				REG_MIN_MAG:   cfg_q.min_magnitude <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_OFFSET_X:  prdata = APB_DW'(cfg_q.offset_x);
			REG_OFFSET_Y:  prdata = APB_DW'(cfg_q.offset_y);
			REG_OFFSET_Z:  prdata = APB_DW'(cfg_q.offset_z);
			REG_SMOOTHING: prdata = APB_DW'(cfg_q.smoothing);
			REG_FILTER_ON: prdata = APB_DW'(cfg_q.filter_on);
			REG_MIN_MAG:   prdata = APB_DW'(cfg_q.min_magnitude);
			default:       prdata = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_smooth_max: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_q.smoothing <= SMOOTH_ONE)
		else $error("smoothing above 1.0");

	a_filter_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (idx == REG_FILTER_ON) |=> cfg_q.filter_on == $past(pwdata[0]))
		else $error("filter enable write lost");

	a_smooth_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && (idx == REG_SMOOTHING) && (pwdata[8:0] > SMOOTH_ONE)
		|=> cfg_q.smoothing == SMOOTH_ONE)
		else $error("smoothing write not clamped");
`endif

endmodule

[hdl/ate_cordic.sv]
// ----------------------------------------------------------------------------
// ate_cordic: iterative CORDIC vectoring unit
// atan2(num, den) one micro-rotation per cycle, result in Q11.7 degrees.
// Left half-plane inputs are mirrored and offset by 180 degrees first.
// ----------------------------------------------------------------------------
module ate_cordic #(
	parameter int CORDIC_STEPS = ate_pkg::ATE_CORDIC_STEPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ate_pkg::cordic_req_t req,
	output ate_pkg::cordic_rsp_t rsp
);
	import ate_pkg::*;

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

	logic                       busy_q, done_q;
	logic [IW-1:0]              i_q;
	logic signed [CORDIC_W-1:0] x_q, y_q, acc_q;
	logic signed [CORDIC_W-1:0] x_nxt, y_nxt, acc_nxt;
	logic signed [CORDIC_W-1:0] dx, dy, tab;
	logic signed [CORDIC_W-1:0] num_w, den_w, x_init, y_init, acc_init;
	logic signed [CORDIC_W-1:0] ang_rnd;
	logic                       zero_in;

	assign num_w   = CORDIC_W'(req.num);
	assign den_w   = CORDIC_W'(req.den);
	assign zero_in = (req.num == '0) && (req.den == '0);

	always_comb begin
		x_init   = den_w <<< CORDIC_SCALE;
		y_init   = num_w <<< CORDIC_SCALE;
		acc_init = '0;
		if (!zero_in && req.den[16]) begin
			x_init   = (-den_w) <<< CORDIC_SCALE;
			y_init   = (-num_w) <<< CORDIC_SCALE;
			acc_init = req.num[16] ? -ACC_HALF_TURN : ACC_HALF_TURN;
		end
	end

	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign tab = CORDIC_W'(atan_step(5'(i_q)));

	// rotate toward the x axis; y == 0 takes the negative direction
	always_comb begin
		if (!y_q[CORDIC_W-1] && (y_q != '0)) begin
			x_nxt   = x_q + dx;
			y_nxt   = y_q - dy;
			acc_nxt = acc_q + tab;
		end else begin
			x_nxt   = x_q - dx;
			y_nxt   = y_q + dy;
			acc_nxt = acc_q - tab;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				i_q <= '0;
				if (zero_in)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= x_init;
			y_q   <= y_init;
			acc_q <= zero_in ? '0 : acc_init;
		end else if (busy_q) begin
			x_q   <= x_nxt;
			y_q   <= y_nxt;
			acc_q <= acc_nxt;
		end
	end

	// round 2^-16 degree to 2^-7 degree
	assign ang_rnd   = acc_q + ACC_ROUND;
	assign rsp.done  = done_q;
	assign rsp.angle = ang_rnd[CORDIC_W-1:CORDIC_W-ANG_W];

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("CORDIC restarted while busy");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (i_q == LAST) && !req.start |=> done_q && !busy_q)
		else $error("CORDIC did not finish after last step");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("CORDIC done held");
`endif

endmodule
